[src/metropolis_annealing_acceptor_defines.svh]
// Assertion helpers used by the checker file.
`ifndef METROPOLIS_ANNEALING_ACCEPTOR_DEFINES_SVH
`define METROPOLIS_ANNEALING_ACCEPTOR_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define MAA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("maa assertion failed");

// The condition must hold in the cycle after the trigger.
`define MAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("maa assertion failed");

`endif

[src/maa_pkg.sv]
`timescale 1ns / 1ps

package maa_pkg;

   localparam int DEFAULT_COST_BITS       = 32;
   localparam int DEFAULT_EXP_TABLE_DEPTH = 2048;

   localparam int TEMP_BITS      = 10;
   localparam int STEP_BITS      = 16;
   localparam int RAND_BITS      = 10;
   localparam int THRESH_BITS    = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int EXP_BITS       = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_TEMPERATURE       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEPS_PER_TEMPERATURE = 1'd1;

   localparam logic [TEMP_BITS-1:0] DEFAULT_MAX_TEMP   = 10'd500;
   localparam logic [STEP_BITS-1:0] DEFAULT_STEPS      = 16'd1;
   localparam logic [EXP_BITS-1:0]  ONE_Q31            = 32'h8000_0000;
   localparam logic [EXP_BITS-1:0]  HALF_Q31           = 32'h4000_0000;
   localparam logic [EXP_BITS-1:0]  EXP_STEP_Q31       = 32'd2139111403;
   localparam logic [THRESH_BITS-1:0] THRESH_SCALE     = 10'd1000;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic fill_done;
      logic fast_path;
      logic div_done;
   } dp_status_type;

endpackage

[src/maa_ifs.sv]
`timescale 1ns / 1ps

interface maa_req_if import maa_pkg::*; #(
   parameter int COST_BITS = DEFAULT_COST_BITS
) ();
   logic                 valid;
   logic                 ready;
   logic [COST_BITS-1:0] candidate_cost;
   logic [RAND_BITS-1:0] random_value;

   modport source (output valid, output candidate_cost, output random_value, input ready);
   modport sink (input valid, input candidate_cost, input random_value, output ready);
endinterface

interface maa_rsp_if import maa_pkg::*; #(
   parameter int COST_BITS = DEFAULT_COST_BITS
) ();
   logic                 valid;
   logic                 ready;
   logic                 accepted;
   logic                 best_changed;
   logic [COST_BITS-1:0] current_cost;
   logic [COST_BITS-1:0] best_cost;
   logic [TEMP_BITS-1:0] temperature;
   logic                 finished;

   modport source (output valid, output accepted, output best_changed, output current_cost,
                   output best_cost, output temperature, output finished, input ready);
   modport sink (input valid, input accepted, input best_changed, input current_cost,
                 input best_cost, input temperature, input finished, output ready);
endinterface

interface maa_csr_if import maa_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink (input valid, input reg_index, input data, output ready);
endinterface

[src/maa_div.sv]
`timescale 1ns / 1ps

module maa_div import maa_pkg::*; #(
   parameter int COST_BITS = DEFAULT_COST_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [COST_BITS-1:0] dividend,
   input  logic [TEMP_BITS-1:0] divisor,
   output logic                 done,
   output logic [COST_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(COST_BITS + 1);

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [COST_BITS-1:0] quo_ff, quo_in;
   logic [TEMP_BITS:0]   rem_ff, rem_in;
   logic [TEMP_BITS-1:0] dvs_ff, dvs_in;
   logic [TEMP_BITS:0]   rem_shift;
   logic                 fits;

   assign rem_shift = {rem_ff[TEMP_BITS-1:0], quo_ff[COST_BITS-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = CNT_BITS'(COST_BITS);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
         quo_in  = {quo_ff[COST_BITS-2:0], fits};
         rem_in  = fits ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/maa_rom.sv]
`timescale 1ns / 1ps

module maa_rom import maa_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = DEFAULT_EXP_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] addr,
   output logic [THRESH_BITS-1:0]             rd_data,
   output logic                               fill_done
);

   localparam int ADDR_BITS = $clog2(EXP_TABLE_DEPTH);
   localparam int STEP_PROD_BITS = 2 * EXP_BITS;
   localparam int THR_PROD_BITS = EXP_BITS + THRESH_BITS;

   logic [THRESH_BITS-1:0]    mem [EXP_TABLE_DEPTH];
   logic [ADDR_BITS:0]        fill_cnt_ff, fill_cnt_in;
   logic [EXP_BITS-1:0]       e_ff, e_in;
   logic [THRESH_BITS-1:0]    rd_data_ff;
   logic [STEP_PROD_BITS-1:0] step_prod;
   logic [THR_PROD_BITS-1:0]  thr_prod;
   logic [THRESH_BITS-1:0]    wr_data;
   logic                      filling;

   // Entry k holds floor(1000 * E_k / 2^31) with E_(k+1) = round(E_k * exp(-1/256)).
   assign filling   = fill_cnt_ff != (ADDR_BITS + 1)'(EXP_TABLE_DEPTH);
   assign step_prod = STEP_PROD_BITS'(e_ff) * STEP_PROD_BITS'(EXP_STEP_Q31)
                      + STEP_PROD_BITS'(HALF_Q31);
   assign thr_prod  = THR_PROD_BITS'(e_ff) * THR_PROD_BITS'(THRESH_SCALE);
   assign wr_data   = thr_prod[EXP_BITS-1 +: THRESH_BITS];

   always_comb begin
      fill_cnt_in = fill_cnt_ff;
      e_in        = e_ff;
      if (filling) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
         e_in        = step_prod[EXP_BITS-1 +: EXP_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
         e_ff        <= ONE_Q31;
      end else begin
         fill_cnt_ff <= fill_cnt_in;
         e_ff        <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (filling) begin
         mem[fill_cnt_ff[ADDR_BITS-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data   = rd_data_ff;
   assign fill_done = !filling;

endmodule

[src/maa_dp.sv]
`timescale 1ns / 1ps

module maa_dp import maa_pkg::*; #(
   parameter int COST_BITS       = DEFAULT_COST_BITS,
   parameter int EXP_TABLE_DEPTH = DEFAULT_EXP_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic [COST_BITS-1:0]      req_candidate_cost,
   input  logic [RAND_BITS-1:0]      req_random_value,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_reg_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic                      rsp_accepted,
   output logic                      rsp_best_changed,
   output logic [COST_BITS-1:0]      rsp_current_cost,
   output logic [COST_BITS-1:0]      rsp_best_cost,
   output logic [TEMP_BITS-1:0]      rsp_temperature,
   output logic                      rsp_finished
);

   localparam int ADDR_BITS = $clog2(EXP_TABLE_DEPTH);

   logic [COST_BITS-1:0]   cand_ff, cand_in;
   logic [RAND_BITS-1:0]   rnd_ff, rnd_in;
   logic [COST_BITS-1:0]   cur_ff, cur_in;
   logic [COST_BITS-1:0]   best_ff, best_in;
   logic                   have_ff, have_in;
   logic [TEMP_BITS-1:0]   temp_ff, temp_in;
   logic [STEP_BITS-1:0]   steps_ff, steps_in;
   logic [STEP_BITS-1:0]   step_cnt_ff, step_cnt_in;
   logic                   out_acc_ff, out_acc_in;
   logic                   out_bchg_ff, out_bchg_in;
   logic [COST_BITS-1:0]   out_cur_ff, out_cur_in;
   logic [COST_BITS-1:0]   out_best_ff, out_best_in;
   logic [TEMP_BITS-1:0]   out_temp_ff, out_temp_in;

   logic [COST_BITS-1:0]   diff;
   logic [COST_BITS-1:0]   quotient;
   logic                   div_done;
   logic [THRESH_BITS-1:0] thr;
   logic                   fill_done;
   logic                   temp_live;
   logic                   cheaper;
   logic                   in_range;
   logic                   acc;
   logic                   bchg;
   logic [STEP_BITS-1:0]   step_next;
   logic [STEP_BITS-1:0]   limit;
   logic                   cool;

   assign diff = cand_ff - cur_ff;

   maa_div #(.COST_BITS(COST_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff),
      .divisor  (temp_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   maa_rom #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_rom (
      .clock     (clock),
      .reset     (reset),
      .addr      (quotient[ADDR_BITS-1:0]),
      .rd_data   (thr),
      .fill_done (fill_done)
   );

   assign temp_live = temp_ff != '0;
   assign cheaper   = cand_ff < cur_ff;
   assign in_range  = quotient < COST_BITS'(EXP_TABLE_DEPTH);
   assign acc       = temp_live && (!have_ff || cheaper
                      || (in_range && (rnd_ff < thr)));
   assign bchg      = acc && (!have_ff || (cand_ff < best_ff));
   assign step_next = step_cnt_ff + 1'b1;
   assign limit     = (steps_ff == '0) ? DEFAULT_STEPS : steps_ff;
   assign cool      = (step_next >= limit) || (step_next == '0);

   assign status.fill_done = fill_done;
   assign status.fast_path = !temp_live || !have_ff || cheaper;
   assign status.div_done  = div_done;

   always_comb begin
      cand_in     = cand_ff;
      rnd_in      = rnd_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      have_in     = have_ff;
      temp_in     = temp_ff;
      steps_in    = steps_ff;
      step_cnt_in = step_cnt_ff;
      out_acc_in  = out_acc_ff;
      out_bchg_in = out_bchg_ff;
      out_cur_in  = out_cur_ff;
      out_best_in = out_best_ff;
      out_temp_in = out_temp_ff;

      if (cmd.capture) begin
         cand_in = req_candidate_cost;
         rnd_in  = req_random_value;
      end

      if (cmd.commit) begin
         if (acc) begin
            cur_in  = cand_ff;
            have_in = 1'b1;
         end
         if (bchg) begin
            best_in = cand_ff;
         end
         if (temp_live) begin
            if (cool) begin
               step_cnt_in = '0;
               temp_in     = temp_ff - 1'b1;
            end else begin
               step_cnt_in = step_next;
            end
         end
         out_acc_in  = acc;
         out_bchg_in = bchg;
         out_cur_in  = cur_in;
         out_best_in = best_in;
         out_temp_in = temp_in;
      end

      if (csr_write) begin
         case (csr_reg_index)
            REG_MAX_TEMPERATURE: begin
               temp_in     = csr_data[TEMP_BITS-1:0];
               step_cnt_in = '0;
            end
            REG_STEPS_PER_TEMPERATURE: begin
               steps_in = csr_data[STEP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         best_ff     <= '0;
         have_ff     <= 1'b0;
         temp_ff     <= DEFAULT_MAX_TEMP;
         steps_ff    <= DEFAULT_STEPS;
         step_cnt_ff <= '0;
      end else begin
         cur_ff      <= cur_in;
         best_ff     <= best_in;
         have_ff     <= have_in;
         temp_ff     <= temp_in;
         steps_ff    <= steps_in;
         step_cnt_ff <= step_cnt_in;
      end
      cand_ff     <= cand_in;
      rnd_ff      <= rnd_in;
      out_acc_ff  <= out_acc_in;
      out_bchg_ff <= out_bchg_in;
      out_cur_ff  <= out_cur_in;
      out_best_ff <= out_best_in;
      out_temp_ff <= out_temp_in;
   end

   assign rsp_accepted     = out_acc_ff;
   assign rsp_best_changed = out_bchg_ff;
   assign rsp_current_cost = out_cur_ff;
   assign rsp_best_cost    = out_best_ff;
   assign rsp_temperature  = out_temp_ff;
   assign rsp_finished     = out_temp_ff == '0;

endmodule

[src/maa_ctrl.sv]
`timescale 1ns / 1ps

module maa_ctrl import maa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   localparam logic [2:0] ST_FILL = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_LOOK = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_FILL: begin
            if (status.fill_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.fast_path) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/metropolis_annealing_acceptor.sv]
`timescale 1ns / 1ps
// A request that needs no division goes from capture to result through the evaluate
// and done states; otherwise the bit-serial divider of cost difference by temperature and a
// table lookup come between. One request is handled at a time, and the next request is
// taken while the last result waits.
// Reset: the threshold table is filled entry by entry, with req ready low.
// Configuration writes are taken at any time, including during that fill.

module metropolis_annealing_acceptor import maa_pkg::*; #(
   parameter int COST_BITS       = DEFAULT_COST_BITS,
   parameter int EXP_TABLE_DEPTH = DEFAULT_EXP_TABLE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   maa_req_if.sink   req_chan,
   maa_rsp_if.source rsp_chan,
   maa_csr_if.sink   csr_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   maa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   maa_dp #(
      .COST_BITS       (COST_BITS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_candidate_cost (req_chan.candidate_cost),
      .req_random_value   (req_chan.random_value),
      .csr_write          (csr_chan.valid),
      .csr_reg_index      (csr_chan.reg_index),
      .csr_data           (csr_chan.data),
      .rsp_accepted       (rsp_chan.accepted),
      .rsp_best_changed   (rsp_chan.best_changed),
      .rsp_current_cost   (rsp_chan.current_cost),
      .rsp_best_cost      (rsp_chan.best_cost),
      .rsp_temperature    (rsp_chan.temperature),
      .rsp_finished       (rsp_chan.finished)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign csr_chan.ready = 1'b1;

endmodule

[src/maa_checker.sv]
`timescale 1ns / 1ps
`include "metropolis_annealing_acceptor_defines.svh"

module maa_checker import maa_pkg::*; #(
   parameter int COST_BITS = DEFAULT_COST_BITS
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_accepted,
   input logic                 rsp_best_changed,
   input logic [COST_BITS-1:0] rsp_current_cost,
   input logic [COST_BITS-1:0] rsp_best_cost,
   input logic [TEMP_BITS-1:0] rsp_temperature,
   input logic                 rsp_finished
);

   `MAA_ASSERT_HOLDS(a_finished_at_zero, clock, reset, rsp_valid, rsp_finished == (rsp_temperature == '0))
   `MAA_ASSERT_HOLDS(a_best_not_above_current, clock, reset, rsp_valid, rsp_best_cost <= rsp_current_cost)
   `MAA_ASSERT_HOLDS(a_new_best_is_current, clock, reset, rsp_valid && rsp_best_changed, rsp_accepted && (rsp_best_cost == rsp_current_cost))
   `MAA_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_current_cost) && $stable(rsp_best_cost))

endmodule

bind metropolis_annealing_acceptor maa_checker #(.COST_BITS(COST_BITS)) u_maa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_accepted     (rsp_chan.accepted),
   .rsp_best_changed (rsp_chan.best_changed),
   .rsp_current_cost (rsp_chan.current_cost),
   .rsp_best_cost    (rsp_chan.best_cost),
   .rsp_temperature  (rsp_chan.temperature),
   .rsp_finished     (rsp_chan.finished)
);

[tb/tb_metropolis_annealing_acceptor.sv]
`timescale 1ns / 1ps

module tb_metropolis_annealing_acceptor;
   import maa_pkg::*;

   localparam int COST_BITS        = DEFAULT_COST_BITS;
   localparam int EXP_TABLE_DEPTH  = DEFAULT_EXP_TABLE_DEPTH;
   localparam int THRESH_ADDR_BITS = $clog2(EXP_TABLE_DEPTH);
   localparam int RANDOM_REQUESTS  = 1530;
   localparam int DIRECTED_ROWS    = 29;
   localparam int SETTLE_CYCLES    = COST_BITS + 8;
   localparam int CYCLE_LIMIT      = 1_500_000;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct packed {
      logic                 accepted;
      logic                 best_changed;
      logic [COST_BITS-1:0] current_cost;
      logic [COST_BITS-1:0] best_cost;
      logic [TEMP_BITS-1:0] temperature;
      logic                 finished;
   } decision_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [COST_BITS-1:0]      cost;
      logic [RAND_BITS-1:0]      draw;
      logic                      known;
      decision_type              want;
   } stim_row_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   mismatch_count;
   int   sender_idle_pct;
   int   receiver_idle_pct;

   logic [THRESH_BITS-1:0] accept_threshold [EXP_TABLE_DEPTH];
   logic [STEP_BITS-1:0]   steps_reg;
   logic [COST_BITS-1:0]   model_current;
   logic [COST_BITS-1:0]   model_best;
   logic                   model_has_solution;
   logic [TEMP_BITS-1:0]   model_temperature;
   logic [STEP_BITS-1:0]   model_step_count;
   decision_type           pending_decisions [$];
   stim_row_type           directed_rows [DIRECTED_ROWS];

   maa_req_if #(.COST_BITS(COST_BITS)) req_chan ();
   maa_rsp_if #(.COST_BITS(COST_BITS)) rsp_chan ();
   maa_csr_if csr_chan ();

   metropolis_annealing_acceptor #(
      .COST_BITS       (COST_BITS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic decision_type judge_candidate(input logic [COST_BITS-1:0] cost,
                                                    input logic [RAND_BITS-1:0] draw);
      decision_type           verdict;
      logic [COST_BITS-1:0]   quotient;
      logic [THRESH_BITS-1:0] threshold;
      logic [STEP_BITS-1:0]   step_limit;
      logic [STEP_BITS-1:0]   next_step;
      verdict = '0;
      if (model_temperature != '0) begin
         if (!model_has_solution || cost < model_current) begin
            verdict.accepted = 1'b1;
         end else begin
            quotient  = (cost - model_current) / COST_BITS'(model_temperature);
            threshold = (quotient < EXP_TABLE_DEPTH) ?
                        accept_threshold[quotient[THRESH_ADDR_BITS-1:0]] : '0;
            verdict.accepted = (draw < threshold);
         end
         if (verdict.accepted) begin
            if (!model_has_solution || cost < model_best) begin
               model_best           = cost;
               verdict.best_changed = 1'b1;
            end
            model_current      = cost;
            model_has_solution = 1'b1;
         end
         step_limit = (steps_reg == '0) ? STEP_BITS'(1) : steps_reg;
         next_step  = model_step_count + 1'b1;
         if (next_step >= step_limit || next_step == '0) begin
            model_step_count  = '0;
            model_temperature = model_temperature - 1'b1;
         end else begin
            model_step_count = next_step;
         end
      end
      verdict.current_cost = model_current;
      verdict.best_cost    = model_best;
      verdict.temperature  = model_temperature;
      verdict.finished     = (model_temperature == '0);
      return verdict;
   endfunction

   function automatic stim_row_type req_row(input logic [COST_BITS-1:0] cost,
                                            input logic [RAND_BITS-1:0] draw);
      stim_row_type row;
      row      = '0;
      row.kind = ROW_REQ;
      row.cost = cost;
      row.draw = draw;
      return row;
   endfunction

   function automatic stim_row_type req_known(input logic [COST_BITS-1:0] cost,
                                              input logic [RAND_BITS-1:0] draw,
                                              input logic accepted, best_changed,
                                              input logic [COST_BITS-1:0] current_cost,
                                              input logic [COST_BITS-1:0] best_cost,
                                              input logic [TEMP_BITS-1:0] temperature,
                                              input logic finished);
      stim_row_type row;
      row       = req_row(cost, draw);
      row.known = 1'b1;
      row.want  = '{accepted, best_changed, current_cost, best_cost, temperature, finished};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] index,
                                            input logic [CSR_DATA_BITS-1:0] value);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.reg_index = index;
      row.data      = value;
      return row;
   endfunction

   task automatic note_mismatch(input string field, input logic [COST_BITS-1:0] want,
                                input logic [COST_BITS-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch in %s: expected %0h, got %0h", field, want, got);
      end
   endtask

   task automatic check_decision(input decision_type want);
      if (rsp_chan.accepted !== want.accepted) begin
         note_mismatch("accepted", COST_BITS'(want.accepted), COST_BITS'(rsp_chan.accepted));
      end
      if (rsp_chan.best_changed !== want.best_changed) begin
         note_mismatch("best_changed", COST_BITS'(want.best_changed),
                       COST_BITS'(rsp_chan.best_changed));
      end
      if (rsp_chan.current_cost !== want.current_cost) begin
         note_mismatch("current_cost", want.current_cost, rsp_chan.current_cost);
      end
      if (rsp_chan.best_cost !== want.best_cost) begin
         note_mismatch("best_cost", want.best_cost, rsp_chan.best_cost);
      end
      if (rsp_chan.temperature !== want.temperature) begin
         note_mismatch("temperature", COST_BITS'(want.temperature),
                       COST_BITS'(rsp_chan.temperature));
      end
      if (rsp_chan.finished !== want.finished) begin
         note_mismatch("finished", COST_BITS'(want.finished), COST_BITS'(rsp_chan.finished));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_decisions.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_chan.current_cost);
         end else begin
            check_decision(pending_decisions.pop_front());
         end
      end
   end

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      wait_idle();
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= index;
      csr_chan.data      <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (index == REG_MAX_TEMPERATURE) begin
         model_temperature = value[TEMP_BITS-1:0];
         model_step_count  = '0;
      end else if (index == REG_STEPS_PER_TEMPERATURE) begin
         steps_reg = value;
      end
   endtask

   task automatic send_request(input stim_row_type row);
      decision_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.candidate_cost <= row.cost;
      req_chan.random_value   <= row.draw;
      do @(posedge clock); while (!req_chan.ready);
      predicted = judge_candidate(row.cost, row.draw);
      pending_decisions.push_back(row.known ? row.want : predicted);
   endtask

   initial begin
      logic [63:0]              scaled;
      logic [COST_BITS-1:0]     cost;
      logic [RAND_BITS-1:0]     draw;
      logic [CSR_DATA_BITS-1:0] csr_value;
      int                       sent;
      int                       burst;
      int                       mode;

      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.candidate_cost <= '0;
      req_chan.random_value   <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.reg_index      <= '0;
      csr_chan.data           <= '0;

      scaled = 64'(ONE_Q31);
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         accept_threshold[THRESH_ADDR_BITS'(k)] =
            THRESH_BITS'((scaled * 64'(THRESH_SCALE)) >> 31);
         scaled = (scaled * 64'(EXP_STEP_Q31) + 64'(HALF_Q31)) >> 31;
      end
      steps_reg          = DEFAULT_STEPS;
      model_temperature  = DEFAULT_MAX_TEMP;
      model_step_count   = '0;
      model_current      = '0;
      model_best         = '0;
      model_has_solution = 1'b0;
      sender_idle_pct    = 14;
      receiver_idle_pct  = 79;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Rows with a typed-in result start from the reset state or are fixed by the
      // extremes; the rest follow the predictor.
      directed_rows = '{
         req_known(32'd100, 10'd0, 1'b1, 1'b1, 32'd100, 32'd100, 10'd499, 1'b0),
         req_known(32'd100, 10'd999, 1'b1, 1'b0, 32'd100, 32'd100, 10'd498, 1'b0),
         req_known(32'd100, 10'd1000, 1'b0, 1'b0, 32'd100, 32'd100, 10'd497, 1'b0),
         req_known(32'd100, 10'd1023, 1'b0, 1'b0, 32'd100, 32'd100, 10'd496, 1'b0),
         req_known(32'd0, 10'd0, 1'b1, 1'b1, 32'd0, 32'd0, 10'd495, 1'b0),
         req_known(32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0, 32'd0, 32'd0, 10'd494, 1'b0),
         csr_row(REG_STEPS_PER_TEMPERATURE, 16'd0),
         req_known(32'h8000_0000, 10'd0, 1'b0, 1'b0, 32'd0, 32'd0, 10'd493, 1'b0),
         csr_row(REG_MAX_TEMPERATURE, 16'hFFFF),
         csr_row(REG_STEPS_PER_TEMPERATURE, 16'd3),
         req_row(32'd2094081, 10'd0),
         req_row(32'd102305, 10'd500),
         req_row(32'd300, 10'd999),
         csr_row(REG_STEPS_PER_TEMPERATURE, 16'hFFFF),
         req_row(32'd2093356, 10'd0),
         req_row(32'd2093355, 10'd0),
         csr_row(REG_STEPS_PER_TEMPERATURE, 16'd1),
         csr_row(REG_MAX_TEMPERATURE, 16'd1),
         req_known(32'd50, 10'd0, 1'b1, 1'b0, 32'd50, 32'd0, 10'd0, 1'b1),
         req_known(32'd10, 10'd0, 1'b0, 1'b0, 32'd50, 32'd0, 10'd0, 1'b1),
         csr_row(REG_MAX_TEMPERATURE, 16'd0),
         req_known(32'd5, 10'd0, 1'b0, 1'b0, 32'd50, 32'd0, 10'd0, 1'b1),
         csr_row(REG_MAX_TEMPERATURE, 16'd2),
         csr_row(REG_STEPS_PER_TEMPERATURE, 16'd5),
         req_row(32'd50, 10'd0),
         req_row(32'd51, 10'd999),
         req_row(32'hFFFF_FFFF, 10'd0),
         csr_row(REG_STEPS_PER_TEMPERATURE, 16'd2),
         req_row(32'd0, 10'd512)
      };
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_csr(directed_rows[i].reg_index, directed_rows[i].data);
         end else begin
            send_request(directed_rows[i]);
         end
      end

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sent < RANDOM_REQUESTS / 3) begin
            sender_idle_pct   = 14;
            receiver_idle_pct = 79;
         end else if (sent < 2 * RANDOM_REQUESTS / 3) begin
            sender_idle_pct   = 79;
            receiver_idle_pct = 14;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end

         case ($urandom_range(9))
            0: csr_value = 16'd1;
            1: csr_value = 16'd1023;
            default: csr_value = 16'($urandom_range(1, 1023));
         endcase
         csr_value[CSR_DATA_BITS-1:TEMP_BITS] = (CSR_DATA_BITS - TEMP_BITS)'($urandom);
         write_csr(REG_MAX_TEMPERATURE, csr_value);

         case ($urandom_range(9))
            0: csr_value = '0;
            1, 2, 3: csr_value = 16'd1;
            4: csr_value = '1;
            5: csr_value = 16'($urandom_range(9, 300));
            default: csr_value = 16'($urandom_range(2, 8));
         endcase
         write_csr(REG_STEPS_PER_TEMPERATURE, csr_value);

         burst = $urandom_range(20, 90);
         repeat (burst) begin
            mode = $urandom_range(9);
            if (mode < 3) begin
               cost = (model_current == '0) ? '0 :
                      model_current - 1'b1 - COST_BITS'($urandom % model_current);
            end else if (mode < 7) begin
               scaled = 64'(model_current)
                      + 64'(model_temperature) * 64'($urandom_range(0, (mode == 6) ? 48 : 2100))
                      + 64'($urandom % (32'(model_temperature) + 32'd1));
               cost = ((scaled >> COST_BITS) != 0) ? '1 : scaled[COST_BITS-1:0];
            end else if (mode == 7) begin
               cost = model_current;
            end else begin
               cost = COST_BITS'({$urandom, $urandom});
            end
            draw = ($urandom_range(19) == 0) ? RAND_BITS'($urandom_range(1000, 1023)) :
                                               RAND_BITS'($urandom_range(0, 999));
            send_request(req_row(cost, draw));
            sent++;
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
